>>> rtl/lgs_pkg.sv
package lgs_pkg;

  // width of the row width register
  localparam int RW_W = 6;

  // row width after reset
  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 6'd30;

  // input beat: one cell of the current generation
  typedef struct packed {
    logic cell_in;
    logic frame_last;
  } cell_beat_t;

  // output beat: one cell of the next generation
  typedef struct packed {
    logic next_cell;
    logic out_last;
  } result_beat_t;

  // results that the stencil core hands to the output queue together, up to two beats
  typedef struct packed {
    logic [1:0]   count;
    result_beat_t a;
    result_beat_t b;
  } push_t;

endpackage

>>> rtl/life_generation_stencil.sv
// A cell beat is registered in the input register on entry; its results are written into
// the output queue registers when the core takes the beat, and leave from the queue head.
// One cell per cycle within a frame while the output queue has room; the frame-closing beat
// is followed by up to row width + 1 flush results, during which no cell is taken.
// Reset (synchronous, rst high) clears line buffers, window and counters and sets the
// row width to 30; a row_width write clears the same frame state.
module life_generation_stencil
  import lgs_pkg::*;
#(
  parameter int MAX_COLUMNS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cell_valid,
  output logic            cell_stall,
  input  cell_beat_t      cell_data,
  output logic            result_valid,
  input  logic            result_stall,
  output result_beat_t    result_data,
  input  logic            cfg_we,
  input  logic [RW_W-1:0] cfg_wdata
);

  logic [RW_W-1:0] row_width;
  logic            inr_valid;
  cell_beat_t      inr;
  logic            take;
  logic [1:0]      room;
  push_t           push;

  // row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  // input register, refilled whenever its beat moves on
  assign cell_stall = inr_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      inr_valid <= 1'b0;
    end else if (!cell_stall) begin
      inr_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cell_stall) begin
      inr <= cell_data;
    end
  end

  // stencil core
  lgs_core #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .row_width (row_width),
    .item_valid(inr_valid),
    .item      (inr),
    .room      (room),
    .take      (take),
    .push      (push)
  );

  // output queue
  lgs_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .valid(result_valid),
    .stall(result_stall),
    .data (result_data)
  );

endmodule

>>> rtl/lgs_outq.sv
module lgs_outq
  import lgs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output logic [1:0]   room,
  output logic         valid,
  input  logic         stall,
  output result_beat_t data
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [1:0]   n;
  logic [1:0]   n_next;
  logic [1:0]   rem;
  logic         pop;
  result_beat_t q0;
  result_beat_t q1;
  result_beat_t q0_next;
  result_beat_t q1_next;
  result_beat_t qa;

  // head beat leaves when the receiver does not stall
  assign pop   = (n != 2'd0) && !stall;
  assign rem   = n - {1'b0, pop};
  assign room  = DEPTH - rem;
  assign valid = (n != 2'd0);
  assign data  = q0;

  // shift out the popped beat, then append new results behind what is left
  always_comb begin
    qa = pop ? q1 : q0;
    case (rem)
      2'd0: begin
        q0_next = push.a;
        q1_next = push.b;
      end
      2'd1: begin
        q0_next = qa;
        q1_next = push.a;
      end
      default: begin
        q0_next = qa;
        q1_next = q1;
      end
    endcase
    n_next = rem + push.count;
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= 2'd0;
    end else begin
      n <= n_next;
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push.count <= room)
    else $error("result push exceeds free queue entries");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    n <= DEPTH)
    else $error("output queue occupancy out of range");

endmodule

>>> rtl/lgs_core.sv
module lgs_core
  import lgs_pkg::*;
#(
  parameter int MAX_COLUMNS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic [RW_W-1:0] row_width,
  input  logic            item_valid,
  input  cell_beat_t      item,
  input  logic [1:0]      room,
  output logic            take,
  output push_t           push
);

  localparam int IW = $clog2(MAX_COLUMNS);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam logic [1:0] ROWS_FULL   = 2'd2;
  localparam logic [3:0] CNT_SURVIVE = 4'd2;
  localparam logic [3:0] CNT_BIRTH   = 4'd3;

  typedef enum logic [2:0] {
    PH_RUN  = 3'b001,
    PH_UP   = 3'b010,
    PH_LAST = 3'b100
  } phase_t;

  // window rows: bits 0-2 upper, 3-5 middle, 6-8 lower, bit 0 of a row is newest
  function automatic logic [8:0] shift_win(input logic [8:0] w, input logic up,
                                           input logic mid, input logic low);
    shift_win = {w[7:6], low, w[4:3], mid, w[1:0], up};
  endfunction

  function automatic logic life_rule(input logic alive, input logic [3:0] cnt);
    if (alive) begin
      life_rule = (cnt == CNT_SURVIVE) || (cnt == CNT_BIRTH);
    end else begin
      life_rule = (cnt == CNT_BIRTH);
    end
  endfunction

  function automatic logic win_rule(input logic [8:0] w);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) cnt = cnt + {3'd0, w[i]};
    end
    win_rule = life_rule(w[4], cnt);
  endfunction

  logic [MAX_COLUMNS-1:0] upper;
  logic [MAX_COLUMNS-1:0] middle;
  logic [8:0]             win;
  logic [IW-1:0]          col;
  logic [1:0]             rows;
  phase_t                 phase;
  logic [IW-1:0]          fcol;
  logic [IW-1:0]          lastc;

  logic [CW-1:0] w_eff;
  logic [CW-1:0] w_m1;
  logic [IW-1:0] c_idx;
  logic          row_end;
  logic [8:0]    win0;
  logic [8:0]    win1;
  logic [8:0]    win2;
  logic [8:0]    winf;
  logic          has_a;
  logic          has_b;
  logic [1:0]    need;
  logic          step;
  logic [CW-1:0] k1;
  logic          k1_in;
  logic [IW-1:0] k1_idx;
  logic [IW-1:0] jm1;
  logic          has_l;
  logic          fcol_lt;
  logic          fcol_end;
  logic          last_hit;
  logic          r_above;
  logic          r_here;
  logic [3:0]    cnt_l;

  // effective row width: zero acts as one, oversize clamps to the buffer depth
  always_comb begin
    if (row_width == '0) begin
      w_eff = CW'(1);
    end else if ({1'b0, row_width} > 7'(MAX_COLUMNS)) begin
      w_eff = CW'(MAX_COLUMNS);
    end else begin
      w_eff = CW'(row_width);
    end
    w_m1 = w_eff - 1'b1;
  end

  // streaming column: shift the window, one result behind, one more at row end
  always_comb begin
    c_idx   = (CW'(col) >= w_eff) ? '0 : col;
    row_end = (CW'(c_idx) == w_m1);
    win0    = (c_idx == '0) ? 9'd0 : win;
    win1    = shift_win(win0, upper[c_idx], middle[c_idx], item.cell_in);
    win2    = shift_win(win1, 1'b0, 1'b0, 1'b0);
    has_a   = (rows != 2'd0) && (c_idx != '0);
    has_b   = !item.frame_last && row_end && (rows != 2'd0);
  end

  // flush: rest of the row above, then the final row over a dead row
  always_comb begin
    k1       = CW'(fcol) + 1'b1;
    k1_in    = (k1 < w_eff);
    k1_idx   = k1[IW-1:0];
    winf     = shift_win(win, k1_in & upper[k1_idx], k1_in & middle[k1_idx], 1'b0);
    fcol_end = (CW'(fcol) == w_m1);
    jm1      = fcol - 1'b1;
    has_l    = (fcol != '0);
    fcol_lt  = (fcol < lastc);
    last_hit = (fcol == lastc);
    r_above  = k1_in & (fcol_lt ? upper[k1_idx] : middle[k1_idx]);
    r_here   = k1_in & fcol_lt & middle[k1_idx];
    cnt_l    = {3'd0, upper[jm1] & has_l} + {3'd0, middle[jm1] & has_l}
             + {3'd0, upper[fcol]} + {3'd0, r_above} + {3'd0, r_here};
  end

  // results of this cycle and whether the queue can hold them
  always_comb begin
    push = '0;
    case (phase)
      PH_RUN: begin
        need   = {1'b0, has_a} + {1'b0, has_b};
        step   = item_valid && (need <= room);
        push.a = has_a ? result_beat_t'{win_rule(win1), 1'b0}
                       : result_beat_t'{win_rule(win2), 1'b0};
        push.b = result_beat_t'{win_rule(win2), 1'b0};
      end
      PH_UP: begin
        need   = 2'd1;
        step   = (room != 2'd0);
        push.a = result_beat_t'{win_rule(winf), 1'b0};
      end
      PH_LAST: begin
        need   = 2'd1;
        step   = (room != 2'd0);
        push.a = result_beat_t'{life_rule(middle[fcol], cnt_l), last_hit};
      end
      default: begin
        need = 2'd0;
        step = 1'b0;
      end
    endcase
    push.count = step ? need : 2'd0;
    take       = step && (phase == PH_RUN);
  end

  // line buffers, window, counters and flush sequencing
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      upper  <= '0;
      middle <= '0;
      win    <= 9'd0;
      col    <= '0;
      rows   <= 2'd0;
      phase  <= PH_RUN;
      fcol   <= '0;
      lastc  <= '0;
    end else if (step) begin
      case (phase)
        PH_RUN: begin
          upper[c_idx]  <= middle[c_idx];
          middle[c_idx] <= item.cell_in;
          lastc         <= c_idx;
          if (item.frame_last) begin
            win   <= win1;
            phase <= (rows != 2'd0) ? PH_UP : PH_LAST;
            fcol  <= (rows != 2'd0) ? c_idx : '0;
          end else if (row_end) begin
            win  <= win2;
            col  <= '0;
            rows <= (rows == ROWS_FULL) ? rows : rows + 2'd1;
          end else begin
            win <= win1;
            col <= c_idx + 1'b1;
          end
        end
        PH_UP: begin
          win <= winf;
          if (fcol_end) begin
            phase <= PH_LAST;
            fcol  <= '0;
          end else begin
            fcol <= fcol + 1'b1;
          end
        end
        PH_LAST: begin
          if (last_hit) begin
            upper  <= '0;
            middle <= '0;
            win    <= 9'd0;
            col    <= '0;
            rows   <= 2'd0;
            phase  <= PH_RUN;
          end else begin
            fcol <= fcol + 1'b1;
          end
        end
        default: begin
          phase <= PH_RUN;
        end
      endcase
    end
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LAST && step && last_hit && !clear)
      |=> (phase == PH_RUN && rows == 2'd0 && col == '0 && upper == '0 && middle == '0))
    else $error("frame state not cleared after final result");

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (take && item.frame_last && !clear) |=> (phase != PH_RUN))
    else $error("frame closing cell did not start the flush");

endmodule

>>> tb/sv/tb_life_generation_stencil.sv
`timescale 1ns / 1ps

module tb_life_generation_stencil
  import lgs_pkg::*;
();

  localparam int MAX_COLS       = 32;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SQUEEZE_CYCLES = 160;
  localparam int RANDOM_CELLS   = 157;
  localparam int CALM_FROM      = 130;
  localparam int DIR_ROWS       = 23;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         cell_valid   = 1'b0;
  logic         cell_stall;
  cell_beat_t   cell_data    = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_beat_t result_data;
  logic         cfg_we       = 1'b0;
  logic [RW_W-1:0] cfg_wdata = '0;

  life_generation_stencil #(.MAX_COLUMNS(MAX_COLS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .cell_data    (cell_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // directed stimulus: optional width write before the beat, then the beat itself;
  // chk rows carry the typed-in result, the rest go through the generation predictor
  typedef struct packed {
    logic            wr;
    logic [RW_W-1:0] wval;
    logic            live;
    logic            last;
    logic            chk;
    logic            nexp;
    logic            ecell;
    logic            elast;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset width 30: first row yields nothing yet
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
    // short one-row frame
    '{1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // zero width acts as one: lone live cell dies
    '{1'b1, 6'd0,  1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    '{1'b0, 6'd0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1},
    // blinker on a 3x3 grid
    '{1'b1, 6'd3,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // 2x2 block stays put
    '{1'b1, 6'd2,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // frame ends on the first cell of a row
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // partial frame, abandoned by the next width write
    '{1'b1, 6'd3,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    // oversized width clamps to the maximum, lone cell dies
    '{1'b1, 6'd63, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}
  };

  // generation predictor state
  logic [RW_W-1:0]     width_reg = ROW_WIDTH_RESET;
  logic [MAX_COLS-1:0] up_row    = '0;
  logic [MAX_COLS-1:0] mid_row   = '0;
  logic [8:0]          win       = '0;
  int                  col       = 0;
  int                  rows_done = 0;

  result_beat_t next_gen_q [$];

  // run bookkeeping
  int sent       = 0;
  int dir_count  = 0;
  int checked    = 0;
  int mismatches = 0;
  int strays     = 0;
  int writes     = 0;
  bit calm       = 1'b0;
  bit squeeze    = 1'b0;

  function automatic void clear_frame();
    up_row    = '0;
    mid_row   = '0;
    win       = '0;
    col       = 0;
    rows_done = 0;
  endfunction

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic logic life_rule(logic alive, int cnt);
    if (alive) return (cnt == 2 || cnt == 3);
    return (cnt == 3);
  endfunction

  // window rows: [2:0] upper, [5:3] middle, [8:6] lower; bit 0 of each row newest
  function automatic void shift_col(logic u, logic m, logic l);
    win = {win[7:6], l, win[4:3], m, win[1:0], u};
  endfunction

  function automatic logic window_next();
    int cnt;
    cnt = 0;
    for (int i = 0; i < 9; i++)
      if (i != 4 && win[i]) cnt++;
    return life_rule(win[4], cnt);
  endfunction

  function automatic void queue_result(logic v, logic l);
    result_beat_t r;
    r.next_cell = v;
    r.out_last  = l;
    next_gen_q.push_back(r);
  endfunction

  // one accepted cell beat: update stencil state, queue every result it completes
  function automatic void life_step(logic x, logic fl);
    int w, c, cnt, p;
    logic above, here;
    w = eff_width();
    c = col;
    if (c >= w) c = 0;
    if (c == 0) win = '0;
    shift_col(up_row[c], mid_row[c], x);
    up_row[c]  = mid_row[c];
    mid_row[c] = x;
    if (rows_done >= 1 && c >= 1) queue_result(window_next(), 1'b0);

    if (!fl) begin
      if (c == w - 1) begin
        if (rows_done >= 1) begin
          shift_col(1'b0, 1'b0, 1'b0);
          queue_result(window_next(), 1'b0);
        end
        col = 0;
        if (rows_done < 2) rows_done++;
      end else begin
        col = c + 1;
      end
      return;
    end

    // finish the row above, the incoming row stopped at column c
    if (rows_done >= 1) begin
      for (int k = c; k < w; k++) begin
        if (k + 1 < w) shift_col(up_row[k+1], mid_row[k+1], 1'b0);
        else shift_col(1'b0, 1'b0, 1'b0);
        queue_result(window_next(), 1'b0);
      end
    end

    // last row with a dead row below
    for (int j = 0; j <= c; j++) begin
      cnt = 0;
      for (int d = -1; d <= 1; d++) begin
        p = j + d;
        if (p >= 0 && p < w) begin
          if (p <= c) begin
            above = up_row[p];
            here  = mid_row[p];
          end else begin
            above = mid_row[p];
            here  = 1'b0;
          end
          cnt += above;
          if (d != 0) cnt += here;
        end
      end
      queue_result(life_rule(mid_row[j], cnt), j == c);
    end
    clear_frame();
  endfunction

  // write the row width once the block has drained
  task automatic set_row_width(input logic [RW_W-1:0] v);
    cell_valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg = v;
    clear_frame();
    writes++;
  endtask

  // offer one cell beat, with an occasional idle burst ahead of it
  task automatic offer_cell(input cell_beat_t b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cell_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_data  <= b;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    sent++;
  endtask

  // result side stall: random bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        result_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (next_gen_q.size() == 0) begin
        strays++;
        if (strays + mismatches <= 10)
          $display("unexpected result beat: next_cell %b out_last %b",
                   result_data.next_cell, result_data.out_last);
      end else begin
        want = next_gen_q.pop_front();
        checked++;
        if (result_data.next_cell !== want.next_cell ||
            result_data.out_last !== want.out_last) begin
          mismatches++;
          if (strays + mismatches <= 10)
            $display("result %0d: next_cell exp %b got %b, out_last exp %b got %b",
                     checked, want.next_cell, result_data.next_cell,
                     want.out_last, result_data.out_last);
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t   r;
    cell_beat_t b;
    int n_before, phase, wv, ew, nframes, kind, dens, rows, len;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.wr) set_row_width(r.wval);
      b.cell_in    = r.live;
      b.frame_last = r.last;
      offer_cell(b);
      n_before = next_gen_q.size();
      life_step(b.cell_in, b.frame_last);
      if (r.chk) begin
        while (next_gen_q.size() > n_before) void'(next_gen_q.pop_back());
        if (r.nexp) queue_result(r.ecell, r.elast);
      end
    end
    dir_count = sent;

    // random frames over a series of row widths, full width first under a long hold
    phase = 0;
    while (sent - dir_count < RANDOM_CELLS) begin
      case (phase)
        0: wv = 32;
        1: wv = 1;
        3: wv = 0;
        5: wv = 63;
        default: wv = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                  : $urandom_range(1, 12);
      endcase
      set_row_width(wv[RW_W-1:0]);
      ew = eff_width();
      if (phase == 0) squeeze = 1'b1;
      nframes = (ew > 12) ? 1 : $urandom_range(1, 3);

      for (int f = 0; f < nframes && sent - dir_count < RANDOM_CELLS; f++) begin
        kind = $urandom_range(0, 9);
        dens = $urandom_range(1, 3);
        if (kind == 0) begin
          // noise: random cells, frame ends anywhere, may be left open
          len = $urandom_range(1, 2 * ew + 2);
          for (int i = 0; i < len && sent - dir_count < RANDOM_CELLS; i++) begin
            calm = (sent - dir_count >= CALM_FROM);
            b.cell_in    = 1'($urandom_range(0, 1));
            b.frame_last = ($urandom_range(0, 7) == 0);
            offer_cell(b);
            life_step(b.cell_in, b.frame_last);
          end
        end else begin
          // well-formed frame, sometimes with a short last row
          rows = (ew > 12) ? $urandom_range(1, 2) : $urandom_range(1, 4);
          for (int rr = 0; rr < rows && sent - dir_count < RANDOM_CELLS; rr++) begin
            len = ew;
            if (rr == rows - 1 && kind <= 2) len = $urandom_range(1, ew);
            for (int i = 0; i < len && sent - dir_count < RANDOM_CELLS; i++) begin
              calm = (sent - dir_count >= CALM_FROM);
              b.cell_in    = ($urandom_range(0, 3) < dens);
              b.frame_last = (rr == rows - 1 && i == len - 1);
              offer_cell(b);
              life_step(b.cell_in, b.frame_last);
            end
          end
        end
      end
      phase++;
    end

    // drain
    cell_valid <= 1'b0;
    calm = 1'b1;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d cell beats (%0d directed), %0d result beats checked",
             sent, dir_count, checked);
    $display("tb: %0d row width writes incl. 0, 1, 32, 63; one long output hold",
             writes);
    if (mismatches == 0 && strays == 0 && next_gen_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
